### rtl/core/owml_pkg.sv
// Shared types, constants and codes for the omni wheel mixer with lock.
package owml_pkg;

   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int NUM_WHEELS          = 3;

   localparam logic [29:0] SIN60_Q30            = 30'd929887697;
   localparam logic [23:0] IDLE_MAX             = 24'hFF_FFFF;
   localparam logic [30:0] INV_RADIUS_RESET     = 31'd65536;
   localparam logic [30:0] LOCK_THRESHOLD_RESET = 31'd66;
   localparam logic [31:0] INT32_MIN            = 32'h8000_0000;
   localparam logic [31:0] INT32_MAX            = 32'h7FFF_FFFF;

   localparam logic [1:0] WHEEL_R = 2'd0;
   localparam logic [1:0] WHEEL_L = 2'd1;
   localparam logic [1:0] WHEEL_B = 2'd2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INV_RADIUS = 3'd0,
      CSR_TRACK      = 3'd1,
      CSR_LOCK_THR   = 3'd2,
      CSR_TO_ENABLE  = 3'd3,
      CSR_TO_TICKS   = 3'd4
   } csr_index_type;

   typedef enum logic {
      CMD_VELOCITY = 1'b0,
      CMD_TICK     = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MROT,
      BK_MX,
      BK_XC,
      BK_NUM,
      BK_MAG,
      BK_HI,
      BK_LO,
      BK_FIN
   } back_state_type;

   typedef struct packed {
      logic [30:0] inv_wheel_radius;
      logic [30:0] wheel_track;
      logic [30:0] lock_threshold;
      logic        timeout_enable;
      logic [23:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [31:0]                 tx;
      logic [31:0]                 ty;
      logic [31:0]                 trot;
      logic [NUM_WHEELS-1:0][31:0] pos;
      logic [NUM_WHEELS-1:0][31:0] spd;
   } tick_type;

   typedef struct packed {
      logic [NUM_WHEELS-1:0][31:0] drive;
      logic [NUM_WHEELS-1:0]       locked;
      logic [NUM_WHEELS-1:0][31:0] hold;
   } result_type;

endpackage

### rtl/core/owml_queue.sv
// Small first-in first-out register queue with show-ahead head.
module owml_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = owml_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/owml_front.sv
// Front end: holds the body velocity targets and idle counter, forwards ticks.
module owml_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  owml_pkg::cfg_type                      cfg,
   input  logic                                   in_valid,
   input  logic                                   in_cmd,
   input  logic [31:0]                            vel_x,
   input  logic [31:0]                            vel_y,
   input  logic [31:0]                            yaw_rate,
   input  logic [owml_pkg::NUM_WHEELS-1:0][31:0]  pos,
   input  logic [owml_pkg::NUM_WHEELS-1:0][31:0]  spd,
   output logic                                   tick_push,
   output owml_pkg::tick_type                     tick_data
);

   logic [31:0] tx_ff, tx_in;
   logic [31:0] ty_ff, ty_in;
   logic [31:0] trot_ff, trot_in;
   logic [23:0] idle_ff, idle_in;
   logic [23:0] idle_inc;

   assign idle_inc = (idle_ff < owml_pkg::IDLE_MAX) ? idle_ff + 1'b1 : idle_ff;

   always_comb begin
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      trot_in   = trot_ff;
      idle_in   = idle_ff;
      tick_push = 1'b0;
      if (in_valid) begin
         unique case (owml_pkg::cmd_type'(in_cmd))
            owml_pkg::CMD_VELOCITY: begin
               tx_in   = vel_x;
               ty_in   = vel_y;
               trot_in = yaw_rate;
               idle_in = '0;
            end
            owml_pkg::CMD_TICK: begin
               idle_in   = idle_inc;
               tick_push = 1'b1;
               if (cfg.timeout_enable && (idle_inc > cfg.timeout_ticks)) begin
                  tx_in   = '0;
                  ty_in   = '0;
                  trot_in = '0;
               end
            end
            default: begin
               idle_in = idle_ff;
            end
         endcase
      end
      tick_data.tx   = tx_in;
      tick_data.ty   = ty_in;
      tick_data.trot = trot_in;
      tick_data.pos  = pos;
      tick_data.spd  = spd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff   <= '0;
         ty_ff   <= '0;
         trot_ff <= '0;
         idle_ff <= '0;
      end else begin
         tx_ff   <= tx_in;
         ty_ff   <= ty_in;
         trot_ff <= trot_in;
         idle_ff <= idle_in;
      end
   end

endmodule

### rtl/core/owml_back.sv
// Back end: shared multiplier sequencer for wheel mixing, saturation and locks.
module owml_back #(
   parameter int FRAC_BITS = owml_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  owml_pkg::cfg_type    cfg,
   input  logic                 tick_valid,
   input  owml_pkg::tick_type   tick_data,
   output logic                 tick_pop,
   input  logic                 res_space,
   output logic                 res_push,
   output owml_pkg::result_type res_data
);

   localparam int NW       = owml_pkg::NUM_WHEELS;
   localparam int XC_SHIFT = 30 - FRAC_BITS;
   localparam int R_SHIFT  = 2 * FRAC_BITS;

   owml_pkg::back_state_type state_ff, state_in;

   logic [1:0]          wheel_ff, wheel_in;
   owml_pkg::tick_type  cur_ff, cur_in;
   logic signed [63:0]  prod_ff, prod_in;
   logic signed [63:0]  rv_ff, rv_in;
   logic signed [63:0]  xc_ff, xc_in;
   logic signed [63:0]  num_ff, num_in;
   logic [63:0]         mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [62:0]         ph_ff, ph_in;
   logic [62:0]         pl_ff, pl_in;
   logic [NW-1:0][31:0] drive_ff, drive_in;
   logic [NW-1:0]       lock_ff, lock_in;
   logic [NW-1:0][31:0] hold_ff, hold_in;

   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [64:0] mul_p;

   logic signed [63:0] ty_w, yh, yf;
   logic [94:0]        prod_full, r_full;
   logic               ge31;
   logic [31:0]        drive_w, dm, sm, spd_w, thr;

   assign mul_p = mul_a * mul_b;

   assign ty_w = {{32{cur_ff.ty[31]}}, cur_ff.ty};
   assign yh   = ty_w <<< (FRAC_BITS - 1);
   assign yf   = ty_w <<< FRAC_BITS;

   always_comb begin
      prod_full = {ph_ff, 32'b0} + {32'b0, pl_ff};
      r_full    = prod_full >> R_SHIFT;
      ge31      = |r_full[94:31];
      if (neg_ff) begin
         drive_w = ge31 ? owml_pkg::INT32_MIN : 32'd0 - r_full[31:0];
         dm      = ge31 ? owml_pkg::INT32_MIN : r_full[31:0];
      end else begin
         drive_w = ge31 ? owml_pkg::INT32_MAX : r_full[31:0];
         dm      = ge31 ? owml_pkg::INT32_MAX : r_full[31:0];
      end
      spd_w = cur_ff.spd[wheel_ff];
      sm    = spd_w[31] ? 32'd0 - spd_w : spd_w;
      thr   = {1'b0, cfg.lock_threshold};
   end

   always_comb begin
      state_in = state_ff;
      wheel_in = wheel_ff;
      cur_in   = cur_ff;
      prod_in  = prod_ff;
      rv_in    = rv_ff;
      xc_in    = xc_ff;
      num_in   = num_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      ph_in    = ph_ff;
      pl_in    = pl_ff;
      drive_in = drive_ff;
      lock_in  = lock_ff;
      hold_in  = hold_ff;
      tick_pop = 1'b0;
      res_push = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         owml_pkg::BK_IDLE: begin
            if (tick_valid && res_space) begin
               cur_in   = tick_data;
               tick_pop = 1'b1;
               wheel_in = owml_pkg::WHEEL_R;
               state_in = owml_pkg::BK_MROT;
            end
         end
         owml_pkg::BK_MROT: begin
            mul_a    = {cur_ff.trot[31], cur_ff.trot};
            mul_b    = {1'b0, cfg.wheel_track};
            prod_in  = mul_p[63:0];
            state_in = owml_pkg::BK_MX;
         end
         owml_pkg::BK_MX: begin
            rv_in    = -prod_ff;
            mul_a    = {cur_ff.tx[31], cur_ff.tx};
            mul_b    = {2'b0, owml_pkg::SIN60_Q30};
            prod_in  = mul_p[63:0];
            state_in = owml_pkg::BK_XC;
         end
         owml_pkg::BK_XC: begin
            xc_in    = prod_ff >>> XC_SHIFT;
            state_in = owml_pkg::BK_NUM;
         end
         owml_pkg::BK_NUM: begin
            case (wheel_ff)
               owml_pkg::WHEEL_R: num_in = rv_ff - xc_ff - yh;
               owml_pkg::WHEEL_L: num_in = rv_ff + xc_ff - yh;
               default:           num_in = rv_ff + yf;
            endcase
            state_in = owml_pkg::BK_MAG;
         end
         owml_pkg::BK_MAG: begin
            neg_in   = num_ff[63];
            mag_in   = num_ff[63] ? $unsigned(-num_ff) : $unsigned(num_ff);
            state_in = owml_pkg::BK_HI;
         end
         owml_pkg::BK_HI: begin
            mul_a    = {1'b0, mag_ff[63:32]};
            mul_b    = {1'b0, cfg.inv_wheel_radius};
            ph_in    = mul_p[62:0];
            state_in = owml_pkg::BK_LO;
         end
         owml_pkg::BK_LO: begin
            mul_a    = {1'b0, mag_ff[31:0]};
            mul_b    = {1'b0, cfg.inv_wheel_radius};
            pl_in    = mul_p[62:0];
            state_in = owml_pkg::BK_FIN;
         end
         owml_pkg::BK_FIN: begin
            drive_in[wheel_ff] = drive_w;
            if (!lock_ff[wheel_ff] && (dm < thr) && (sm < thr)) begin
               hold_in[wheel_ff] = cur_ff.pos[wheel_ff];
               lock_in[wheel_ff] = 1'b1;
            end else if (lock_ff[wheel_ff] && (dm > thr)) begin
               lock_in[wheel_ff] = 1'b0;
            end
            if (wheel_ff == owml_pkg::WHEEL_B) begin
               res_push = 1'b1;
               state_in = owml_pkg::BK_IDLE;
            end else begin
               wheel_in = wheel_ff + 1'b1;
               state_in = owml_pkg::BK_NUM;
            end
         end
         default: begin
            state_in = owml_pkg::BK_IDLE;
         end
      endcase
      res_data.drive  = drive_in;
      res_data.locked = lock_in;
      res_data.hold   = hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= owml_pkg::BK_IDLE;
         wheel_ff <= owml_pkg::WHEEL_R;
         lock_ff  <= '0;
         hold_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wheel_ff <= wheel_in;
         lock_ff  <= lock_in;
         hold_ff  <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      prod_ff  <= prod_in;
      rv_ff    <= rv_in;
      xc_ff    <= xc_in;
      num_ff   <= num_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      ph_ff    <= ph_in;
      pl_ff    <= pl_in;
      drive_ff <= drive_in;
   end

endmodule

### rtl/core/omni_wheel_mixer_with_lock_core.sv
// Top level of the three-wheel omni drive mixer with per-wheel standstill lock.
//
// Input queue side: push an item while full is low. A velocity command
// (req_cmd low) updates the body targets and clears the idle counter; it
// gives no result. A control tick (req_cmd high) is stamped with the
// current targets (zeroed on timeout) and queued for the back end.
// The back end works one tick at a time through a single 33x32 multiplier:
// it takes the tick, runs three setup steps, then five steps per wheel.
// Ticks may keep arriving until the internal tick queue fills.
// Result side: a result waits at the rsp_ ports while empty is low and is
// taken when pop is high. An accepted tick passes through the tick queue, the
// back-end steps and the result queue before its result is at the rsp_ ports.
// When the receiver stalls, results collect in the result queue; once it is
// full the back end holds, the tick queue fills and full rises.
// Configuration: a write on valid/ready (ready always high) at csr_index;
// write only while the block is idle. Indexes beyond the list are dropped.
// Reset (synchronous, active high) clears targets, idle counter, locks, held
// positions, both queues and restores register defaults.
module omni_wheel_mixer_with_lock_core #(
   parameter int FRAC_BITS   = owml_pkg::FRAC_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = owml_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 valid,
   output logic                                 ready,
   input  logic [owml_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [owml_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_cmd,
   input  logic [31:0]                          req_vel_x,
   input  logic [31:0]                          req_vel_y,
   input  logic [31:0]                          req_yaw_rate,
   input  logic [31:0]                          req_wheel_pos_r,
   input  logic [31:0]                          req_wheel_pos_l,
   input  logic [31:0]                          req_wheel_pos_b,
   input  logic [31:0]                          req_wheel_spd_r,
   input  logic [31:0]                          req_wheel_spd_l,
   input  logic [31:0]                          req_wheel_spd_b,
   output logic                                 empty,
   input  logic                                 pop,
   output logic [31:0]                          rsp_drive_r,
   output logic [31:0]                          rsp_drive_l,
   output logic [31:0]                          rsp_drive_b,
   output logic                                 rsp_locked_r,
   output logic                                 rsp_locked_l,
   output logic                                 rsp_locked_b,
   output logic [31:0]                          rsp_hold_pos_r,
   output logic [31:0]                          rsp_hold_pos_l,
   output logic [31:0]                          rsp_hold_pos_b
);

   localparam int NW = owml_pkg::NUM_WHEELS;

   owml_pkg::cfg_type    cfg_ff, cfg_in;
   owml_pkg::tick_type   front_tick, back_tick;
   owml_pkg::result_type back_res, rsp_res;

   logic                in_accept;
   logic                mid_push, mid_full, mid_empty, tick_pop;
   logic                res_push, out_full;
   logic [NW-1:0][31:0] req_pos, req_spd;

   assign ready     = 1'b1;
   assign in_accept = push && !full;
   assign full      = mid_full;
   assign req_pos   = {req_wheel_pos_b, req_wheel_pos_l, req_wheel_pos_r};
   assign req_spd   = {req_wheel_spd_b, req_wheel_spd_l, req_wheel_spd_r};

   always_comb begin
      cfg_in = cfg_ff;
      if (valid && ready) begin
         unique case (csr_index)
            owml_pkg::CSR_INV_RADIUS: cfg_in.inv_wheel_radius = csr_wdata[30:0];
            owml_pkg::CSR_TRACK:      cfg_in.wheel_track      = csr_wdata[30:0];
            owml_pkg::CSR_LOCK_THR:   cfg_in.lock_threshold   = csr_wdata[30:0];
            owml_pkg::CSR_TO_ENABLE:  cfg_in.timeout_enable   = csr_wdata[0];
            owml_pkg::CSR_TO_TICKS:   cfg_in.timeout_ticks    = csr_wdata[23:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_wheel_radius <= owml_pkg::INV_RADIUS_RESET;
         cfg_ff.wheel_track      <= '0;
         cfg_ff.lock_threshold   <= owml_pkg::LOCK_THRESHOLD_RESET;
         cfg_ff.timeout_enable   <= 1'b0;
         cfg_ff.timeout_ticks    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   owml_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (in_accept),
      .in_cmd    (req_cmd),
      .vel_x     (req_vel_x),
      .vel_y     (req_vel_y),
      .yaw_rate  (req_yaw_rate),
      .pos       (req_pos),
      .spd       (req_spd),
      .tick_push (mid_push),
      .tick_data (front_tick)
   );

   owml_queue #(
      .WIDTH ($bits(owml_pkg::tick_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_tick_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (front_tick),
      .full      (mid_full),
      .pop       (tick_pop),
      .pop_data  (back_tick),
      .empty     (mid_empty)
   );

   owml_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .tick_valid (!mid_empty),
      .tick_data  (back_tick),
      .tick_pop   (tick_pop),
      .res_space  (!out_full),
      .res_push   (res_push),
      .res_data   (back_res)
   );

   owml_queue #(
      .WIDTH ($bits(owml_pkg::result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (back_res),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_res),
      .empty     (empty)
   );

   assign rsp_drive_r    = rsp_res.drive[owml_pkg::WHEEL_R];
   assign rsp_drive_l    = rsp_res.drive[owml_pkg::WHEEL_L];
   assign rsp_drive_b    = rsp_res.drive[owml_pkg::WHEEL_B];
   assign rsp_locked_r   = rsp_res.locked[owml_pkg::WHEEL_R];
   assign rsp_locked_l   = rsp_res.locked[owml_pkg::WHEEL_L];
   assign rsp_locked_b   = rsp_res.locked[owml_pkg::WHEEL_B];
   assign rsp_hold_pos_r = rsp_res.hold[owml_pkg::WHEEL_R];
   assign rsp_hold_pos_l = rsp_res.hold[owml_pkg::WHEEL_L];
   assign rsp_hold_pos_b = rsp_res.hold[owml_pkg::WHEEL_B];

   a_result_room : assert property (@(posedge clock) disable iff (reset)
      res_push |-> !out_full)
      else $error("result pushed into a full result queue");

   a_tick_present : assert property (@(posedge clock) disable iff (reset)
      tick_pop |-> !mid_empty)
      else $error("back end took a tick from an empty queue");

   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      tick_pop |=> !tick_pop)
      else $error("back end took a second tick while busy");

   a_tick_room : assert property (@(posedge clock) disable iff (reset)
      mid_push |-> !mid_full)
      else $error("tick pushed into a full tick queue");

endmodule
